### src/ookpwc_pkg.sv
// Shared types and constants of the on-off-keyed pulse width code decoder.
`timescale 1ns / 1ps

package ookpwc_pkg;

	// Period lengths and all threshold registers are this wide.
	localparam int LEN_W = 25;
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	// Timer wrap counter width and its saturation value.
	localparam int WRAP_W = 8;
	localparam logic [WRAP_W-1:0] WRAP_MAX = {WRAP_W{1'b1}};

	// Configuration port geometry.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int REG_IDX_W = 3;

	// Register indexes.
	localparam logic [REG_IDX_W-1:0] REG_PAUSE_MIN = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PAUSE_MAX = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SHORT_MIN = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SHORT_MAX = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BIT_MIN   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_BIT_MAX   = 3'd5;

	// Register reset values.
	localparam logic [LEN_W-1:0] PAUSE_MIN_RST = 25'd9000;
	localparam logic [LEN_W-1:0] PAUSE_MAX_RST = 25'd20000;
	localparam logic [LEN_W-1:0] SHORT_MIN_RST = 25'd200;
	localparam logic [LEN_W-1:0] SHORT_MAX_RST = 25'd500;
	localparam logic [LEN_W-1:0] BIT_MIN_RST   = 25'd800;
	localparam logic [LEN_W-1:0] BIT_MAX_RST   = 25'd1200;

	// Command codes of an input word.
	localparam int CMD_W = 2;
	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CAP_HIGH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CAP_LOW  = 2'd2;

	// Sync state codes as reported on the result port.
	localparam int SYNC_W = 2;
	localparam logic [SYNC_W-1:0] SYNC_PAUSE = 2'd0;
	localparam logic [SYNC_W-1:0] SYNC_SHORT = 2'd1;
	localparam logic [SYNC_W-1:0] SYNC_BITS  = 2'd2;

	// Threshold register set.
	typedef struct packed {
		logic [LEN_W-1:0] pause_min;
		logic [LEN_W-1:0] pause_max;
		logic [LEN_W-1:0] short_min;
		logic [LEN_W-1:0] short_max;
		logic [LEN_W-1:0] bit_min;
		logic [LEN_W-1:0] bit_max;
	} cfg_t;

	// Decoded command of the word being processed.
	typedef struct packed {
		logic tick;
		logic capture;
		logic high;
	} step_t;

endpackage

### src/ookpwc_cfg.sv
// Configuration register file with its bus port.
`timescale 1ns / 1ps

module ookpwc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ookpwc_pkg::ADDR_W-1:0]  paddr,
	input  logic [ookpwc_pkg::DATA_W-1:0]  pwdata,
	output logic [ookpwc_pkg::DATA_W-1:0]  prdata,
	output logic                           pready,
	output ookpwc_pkg::cfg_t               cfg
);

	logic [ookpwc_pkg::REG_IDX_W-1:0] idx;
	logic                             wr_en;
	logic [ookpwc_pkg::LEN_W-1:0]     wdata;
	logic [ookpwc_pkg::LEN_W-1:0]     rdata;
	ookpwc_pkg::cfg_t                 cfg_q;

	assign idx    = paddr[ookpwc_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign wdata  = pwdata[ookpwc_pkg::LEN_W-1:0];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes; writes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pause_min <= ookpwc_pkg::PAUSE_MIN_RST;
			cfg_q.pause_max <= ookpwc_pkg::PAUSE_MAX_RST;
			cfg_q.short_min <= ookpwc_pkg::SHORT_MIN_RST;
			cfg_q.short_max <= ookpwc_pkg::SHORT_MAX_RST;
			cfg_q.bit_min   <= ookpwc_pkg::BIT_MIN_RST;
			cfg_q.bit_max   <= ookpwc_pkg::BIT_MAX_RST;
		end else if (wr_en) begin
			case (idx)
				ookpwc_pkg::REG_PAUSE_MIN: cfg_q.pause_min <= wdata;
				ookpwc_pkg::REG_PAUSE_MAX: cfg_q.pause_max <= wdata;
				ookpwc_pkg::REG_SHORT_MIN: cfg_q.short_min <= wdata;
				ookpwc_pkg::REG_SHORT_MAX: cfg_q.short_max <= wdata;
				ookpwc_pkg::REG_BIT_MIN:   cfg_q.bit_min   <= wdata;
				ookpwc_pkg::REG_BIT_MAX:   cfg_q.bit_max   <= wdata;
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		case (idx)
			ookpwc_pkg::REG_PAUSE_MIN: rdata = cfg_q.pause_min;
			ookpwc_pkg::REG_PAUSE_MAX: rdata = cfg_q.pause_max;
			ookpwc_pkg::REG_SHORT_MIN: rdata = cfg_q.short_min;
			ookpwc_pkg::REG_SHORT_MAX: rdata = cfg_q.short_max;
			ookpwc_pkg::REG_BIT_MIN:   rdata = cfg_q.bit_min;
			ookpwc_pkg::REG_BIT_MAX:   rdata = cfg_q.bit_max;
			default:                   rdata = '0;
		endcase
	end

	assign prdata = ookpwc_pkg::DATA_W'(rdata);

endmodule

### src/ookpwc_period.sv
// Timer wrap counter and period length calculation.
`timescale 1ns / 1ps

module ookpwc_period #(
	parameter int STAMP_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step_en,
	input  ookpwc_pkg::step_t            step,
	input  logic [STAMP_WIDTH-1:0]       stamp,
	input  logic                         pending,
	output logic [ookpwc_pkg::LEN_W-1:0] len
);

	localparam int WR_W  = ookpwc_pkg::WRAP_W + 1;
	localparam int SUM_W = WR_W + STAMP_WIDTH;
	localparam int EXT_W = (SUM_W > ookpwc_pkg::LEN_W) ? SUM_W : ookpwc_pkg::LEN_W;

	logic [ookpwc_pkg::WRAP_W-1:0] wrap_count_q;
	logic [STAMP_WIDTH-1:0]        last_stamp_q;
	logic [WR_W-1:0]               wraps;
	logic [WR_W-1:0]               wraps_adj;
	logic [STAMP_WIDTH-1:0]        diff;
	logic                          back;
	logic [EXT_W-1:0]              full;

	// The timestamp difference wraps modulo the timer width; a backward
	// stamp borrows one counted wrap.
	assign wraps     = {1'b0, wrap_count_q} + WR_W'(pending);
	assign back      = stamp < last_stamp_q;
	assign diff      = stamp - last_stamp_q;
	assign wraps_adj = back ? wraps - WR_W'(1) : wraps;
	assign full      = EXT_W'({wraps_adj, diff});

	// Saturate on underflow and on lengths past the register range.
	always_comb begin
		if (back && wraps == '0) begin
			len = ookpwc_pkg::LEN_MAX;
		end else if (full > EXT_W'(ookpwc_pkg::LEN_MAX)) begin
			len = ookpwc_pkg::LEN_MAX;
		end else begin
			len = full[ookpwc_pkg::LEN_W-1:0];
		end
	end

	// Wrap counting and timestamp history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_count_q <= '0;
			last_stamp_q <= '0;
		end else if (step_en) begin
			if (step.tick) begin
				if (wrap_count_q != ookpwc_pkg::WRAP_MAX) begin
					wrap_count_q <= wrap_count_q + ookpwc_pkg::WRAP_W'(1);
				end
			end else if (step.capture) begin
				wrap_count_q <= '0;
				last_stamp_q <= stamp;
			end
		end
	end

endmodule

### src/ookpwc_sync.sv
// Sync state machine and code bit gathering.
`timescale 1ns / 1ps

module ookpwc_sync #(
	parameter int CODE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_en,
	input  ookpwc_pkg::step_t             step,
	input  logic [ookpwc_pkg::LEN_W-1:0]  len,
	input  ookpwc_pkg::cfg_t              cfg,
	output logic                          delivered,
	output logic [CODE_BITS-1:0]          code_next,
	output logic [ookpwc_pkg::SYNC_W-1:0] sync_next
);

	localparam int CNT_W = $clog2(CODE_BITS + 2);

	typedef enum logic [2:0] {
		ST_PAUSE = 3'b001,
		ST_SHORT = 3'b010,
		ST_BITS  = 3'b100
	} state_t;

	state_t                       state_q, state_d;
	logic [ookpwc_pkg::LEN_W-1:0] last_period_q;
	logic [CODE_BITS-1:0]         shift_q, shift_d;
	logic [CNT_W-1:0]             count_q, count_d;
	logic [CODE_BITS-1:0]         decoded_q, decoded_d;
	logic [ookpwc_pkg::LEN_W:0]   bit_span;
	logic [CODE_BITS-1:0]         set_mask;
	logic                         deliver;

	assign bit_span = {1'b0, last_period_q} + {1'b0, len};

	// One-hot mask of the bit position the next received bit goes to.
	always_comb begin
		for (int i = 0; i < CODE_BITS; i++) begin
			set_mask[i] = (count_q == CNT_W'(i));
		end
	end

	// Next state on a capture word.
	always_comb begin
		state_d   = state_q;
		shift_d   = shift_q;
		count_d   = count_q;
		decoded_d = decoded_q;
		deliver   = 1'b0;
		if (step.capture) begin
			if (len >= cfg.pause_min) begin
				if (step.high || len > cfg.pause_max) begin
					state_d = ST_PAUSE;
				end else begin
					if (state_q == ST_BITS && count_q == CNT_W'(CODE_BITS)) begin
						decoded_d = shift_q;
						deliver   = 1'b1;
					end
					state_d = ST_SHORT;
				end
			end else if (state_q == ST_BITS) begin
				if (len > cfg.bit_max) begin
					state_d = ST_PAUSE;
				end else if (step.high) begin
					if (bit_span < {1'b0, cfg.bit_min} || bit_span > {1'b0, cfg.bit_max}) begin
						state_d = ST_PAUSE;
					end else begin
						if (len > last_period_q && count_q < CNT_W'(CODE_BITS)) begin
							shift_d = shift_q | set_mask;
						end
						if (count_q < CNT_W'(CODE_BITS + 1)) begin
							count_d = count_q + CNT_W'(1);
						end
					end
				end
			end else if (state_q == ST_SHORT && step.high && len >= cfg.short_min
				&& len <= cfg.short_max) begin
				shift_d = '0;
				count_d = '0;
				state_d = ST_BITS;
			end else begin
				state_d = ST_PAUSE;
			end
		end
	end

	// Reported state code.
	always_comb begin
		case (state_d)
			ST_PAUSE: sync_next = ookpwc_pkg::SYNC_PAUSE;
			ST_SHORT: sync_next = ookpwc_pkg::SYNC_SHORT;
			ST_BITS:  sync_next = ookpwc_pkg::SYNC_BITS;
			default:  sync_next = ookpwc_pkg::SYNC_PAUSE;
		endcase
	end

	assign delivered = deliver;
	assign code_next = decoded_d;

	// State registers advance once per processed word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_PAUSE;
			last_period_q <= '0;
			shift_q       <= '0;
			count_q       <= '0;
			decoded_q     <= '0;
		end else if (step_en) begin
			state_q   <= state_d;
			shift_q   <= shift_d;
			count_q   <= count_d;
			decoded_q <= decoded_d;
			if (step.capture) begin
				last_period_q <= len;
			end
		end
	end

endmodule

### src/ook_pulse_width_code_decoder.sv
// Top level of the on-off-keyed pulse width code decoder.
`timescale 1ns / 1ps

// Decodes a remote control code from edge timestamps. Each input word is a
// timer wrap tick or an edge capture; every word yields exactly one result
// word carrying the current code, the sync state and a flag that marks the
// word on which a complete code arrived. The block takes one word per clock
// cycle unless the result side stalls: a word sits in the input register
// while the period length and the sync state machine are evaluated, and
// its result is then held in the output register. A stalled result holds
// only the word behind it; the input register accepts whenever the output
// register can take its word. The user must write thresholds through the
// register port while no word is in flight; the block does not enforce it.
module ook_pulse_width_code_decoder #(
	parameter int CODE_BITS   = 12,
	parameter int STAMP_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [ookpwc_pkg::CMD_W-1:0]  cmd,
	input  logic [STAMP_WIDTH-1:0]        capture_value,
	input  logic                          update_pending,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          code_valid,
	output logic [CODE_BITS-1:0]          code,
	output logic [ookpwc_pkg::SYNC_W-1:0] sync_state,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ookpwc_pkg::ADDR_W-1:0] paddr,
	input  logic [ookpwc_pkg::DATA_W-1:0] pwdata,
	output logic [ookpwc_pkg::DATA_W-1:0] prdata,
	output logic                          pready
);

	logic                          v_s1;
	logic [ookpwc_pkg::CMD_W-1:0]  cmd_s1;
	logic [STAMP_WIDTH-1:0]        stamp_s1;
	logic                          pend_s1;
	logic                          adv;
	ookpwc_pkg::step_t             step;
	ookpwc_pkg::cfg_t              cfg;
	logic [ookpwc_pkg::LEN_W-1:0]  len;
	logic                          delivered;
	logic [CODE_BITS-1:0]          code_next;
	logic [ookpwc_pkg::SYNC_W-1:0] sync_next;
	logic                          result_valid_q;
	logic                          code_valid_q;
	logic [CODE_BITS-1:0]          code_q;
	logic [ookpwc_pkg::SYNC_W-1:0] sync_state_q;

	// The input word moves on when the output register is free or drains.
	assign adv        = v_s1 && (!result_valid_q || !result_stall);
	assign item_stall = v_s1 && !adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!item_stall) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1   <= cmd;
			stamp_s1 <= capture_value;
			pend_s1  <= update_pending;
		end
	end

	// Command decode; the unused code is neither a tick nor a capture.
	assign step.tick    = (cmd_s1 == ookpwc_pkg::CMD_TICK);
	assign step.high    = (cmd_s1 == ookpwc_pkg::CMD_CAP_HIGH);
	assign step.capture = (cmd_s1 == ookpwc_pkg::CMD_CAP_HIGH)
		|| (cmd_s1 == ookpwc_pkg::CMD_CAP_LOW);

	ookpwc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ookpwc_period #(
		.STAMP_WIDTH (STAMP_WIDTH)
	) u_period (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.step    (step),
		.stamp   (stamp_s1),
		.pending (pend_s1),
		.len     (len)
	);

	ookpwc_sync #(
		.CODE_BITS (CODE_BITS)
	) u_sync (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (adv),
		.step      (step),
		.len       (len),
		.cfg       (cfg),
		.delivered (delivered),
		.code_next (code_next),
		.sync_next (sync_next)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			code_valid_q <= delivered;
			code_q       <= code_next;
			sync_state_q <= sync_next;
		end
	end

	assign result_valid = result_valid_q;
	assign code_valid   = code_valid_q;
	assign code         = code_q;
	assign sync_state   = sync_state_q;

`ifndef SYNTHESIS
	// A delivered code always leaves the machine waiting for the sync pulse.
	a_code_in_short: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && code_valid |-> sync_state == ookpwc_pkg::SYNC_SHORT)
		else $error("code delivered outside the short pulse wait state");

	// The input side only stalls while holding a word.
	a_stall_holds_word: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> v_s1)
		else $error("input stalled with an empty input register");

	// A new result can only come from a word in the input register.
	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(v_s1))
		else $error("result appeared without a word in the input register");
`endif

endmodule
